// ===== src/fpdf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpdf_pkg
// shared widths, constants and types of the fixed-point decimal formatter
// ----------------------------------------------------------------------------
package fpdf_pkg;

  localparam int IN_W     = 32;
  localparam int CHAR_W   = 8;
  localparam int DIGIT_W  = 4;
  localparam int NUM_FRAC = 4;
  localparam int NUM_CHARS = 6;
  localparam int CNT_W    = 3;

  // values below the limit fit in 17 bits
  localparam int REM_W    = 17;
  localparam logic [IN_W-1:0] VALUE_LIMIT = 32'd100000;

  // x / 10 == (x * MUL_K) >> MUL_SH, exact for x < 2^22
  localparam int K_W      = 20;
  localparam int MUL_SH   = 23;
  localparam logic [K_W-1:0] MUL_K = 20'hCCCCD;
  localparam int PROD_W   = REM_W + K_W;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_NINE = 8'h39;
  localparam logic [CHAR_W-1:0] ASCII_DOT  = 8'h2E;

  localparam logic [CNT_W-1:0] CNT_FULL = 3'd6;
  localparam logic [CNT_W-1:0] CNT_ONE  = 3'd1;
  localparam logic [CNT_W-1:0] CNT_ZERO = 3'd0;

  // work item moving down the digit pipe
  typedef struct packed {
    logic [REM_W-1:0]            rem;
    logic [NUM_FRAC*DIGIT_W-1:0] digits;
  } fpdf_work_t;

endpackage

// ===== src/fpdf_div10_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpdf_div10_stage
// one pipe stage: peels the low decimal digit off the remaining value
// ----------------------------------------------------------------------------
module fpdf_div10_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  fpdf_pkg::fpdf_work_t in_work,
  output logic                out_valid,
  output fpdf_pkg::fpdf_work_t out_work
);

  logic [fpdf_pkg::PROD_W-1:0] prod;
  logic [fpdf_pkg::REM_W-1:0]  quot;
  logic [fpdf_pkg::REM_W-1:0]  quot_x10;
  logic [fpdf_pkg::REM_W-1:0]  digit_full;
  fpdf_pkg::fpdf_work_t        work_nxt;
  logic                        valid_r;
  fpdf_pkg::fpdf_work_t        work_r;

  // reciprocal multiply for the divide by ten
  assign prod = fpdf_pkg::PROD_W'(in_work.rem) * fpdf_pkg::PROD_W'(fpdf_pkg::MUL_K);
  assign quot = fpdf_pkg::REM_W'(prod >> fpdf_pkg::MUL_SH);
  assign quot_x10 = (quot << 3) + (quot << 1);
  assign digit_full = in_work.rem - quot_x10;

  always_comb begin
    work_nxt.rem = quot;
    // new digit enters at the top, older ones move down
    work_nxt.digits = {digit_full[fpdf_pkg::DIGIT_W-1:0],
                       in_work.digits[fpdf_pkg::NUM_FRAC*fpdf_pkg::DIGIT_W-1:fpdf_pkg::DIGIT_W]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      work_r <= work_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_work  = work_r;

endmodule

// ===== src/fpdf_serializer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpdf_serializer
// turns a finished digit set into six ascii beats, one per cycle
// ----------------------------------------------------------------------------
module fpdf_serializer (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  fpdf_pkg::fpdf_work_t        in_work,
  output logic                        stall,
  output logic                        out_strobe,
  output logic [fpdf_pkg::CHAR_W-1:0] out_text_char,
  output logic                        out_is_last
);

  localparam int BUF_W = fpdf_pkg::NUM_CHARS * fpdf_pkg::CHAR_W;

  logic [BUF_W-1:0]           buf_r;
  logic [BUF_W-1:0]           buf_nxt;
  logic [BUF_W-1:0]           load_chars;
  logic [fpdf_pkg::CNT_W-1:0] cnt_r;
  logic [fpdf_pkg::CNT_W-1:0] cnt_nxt;
  logic                       load_ok;
  logic                       load;

  function automatic logic [fpdf_pkg::CHAR_W-1:0] to_ascii(
    input logic [fpdf_pkg::DIGIT_W-1:0] d
  );
    to_ascii = fpdf_pkg::ASCII_ZERO + fpdf_pkg::CHAR_W'(d);
  endfunction

  assign load_chars = {to_ascii(in_work.rem[fpdf_pkg::DIGIT_W-1:0]),
                       fpdf_pkg::ASCII_DOT,
                       to_ascii(in_work.digits[15:12]),
                       to_ascii(in_work.digits[11:8]),
                       to_ascii(in_work.digits[7:4]),
                       to_ascii(in_work.digits[3:0])};

  // take a new run when empty or when the last beat goes out now
  assign load_ok = (cnt_r == fpdf_pkg::CNT_ZERO) || (cnt_r == fpdf_pkg::CNT_ONE);
  assign load    = in_valid && load_ok;
  assign stall   = in_valid && !load_ok;

  always_comb begin
    buf_nxt = buf_r;
    cnt_nxt = cnt_r;
    if (load) begin
      buf_nxt = load_chars;
      cnt_nxt = fpdf_pkg::CNT_FULL;
    end else if (cnt_r != fpdf_pkg::CNT_ZERO) begin
      buf_nxt = buf_r << fpdf_pkg::CHAR_W;
      cnt_nxt = cnt_r - fpdf_pkg::CNT_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= fpdf_pkg::CNT_ZERO;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
  end

  assign out_strobe    = (cnt_r != fpdf_pkg::CNT_ZERO);
  assign out_text_char = buf_r[BUF_W-1 -: fpdf_pkg::CHAR_W];
  assign out_is_last   = (cnt_r == fpdf_pkg::CNT_ONE);

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= fpdf_pkg::CNT_FULL)
    else $error("beat counter out of range");

  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_is_last |=> out_strobe)
    else $error("gap inside a run");

  a_first_digit: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_strobe && (out_text_char >= fpdf_pkg::ASCII_ZERO)
             && (out_text_char <= fpdf_pkg::ASCII_NINE))
    else $error("first beat of a run is not a digit");

  a_dot_second: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> ##1 out_strobe && (out_text_char == fpdf_pkg::ASCII_DOT))
    else $error("second beat of a run is not the dot");

endmodule

// ===== src/fixed_point_decimal_formatter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_decimal_formatter
// formats a time value in 0.1 ms units as six ascii characters D.DDDD
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake            payload
//   input     in         start / busy         in_time_value[31:0]
//   result    out        out_strobe (no back) out_text_char[7:0], out_is_last
//
// - a value is taken at an edge with start high and busy low; values of
//   100000 or more are taken and dropped, giving no beats
// - pipe: input register, four divide-by-ten stages, serializer; the first
//   character reaches the outputs once the serializer loads the digit set
// - the serializer sends one beat per cycle, so its six-beat runs set the
//   sustained rate; the pipe takes values every cycle until it fills
// - busy rises when a finished digit set waits on the serializer; the whole
//   pipe then holds, nothing is lost or repeated
// - synchronous active-low reset clears the valid bits and beat counter
//
module fixed_point_decimal_formatter (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [fpdf_pkg::IN_W-1:0]   in_time_value,
  output logic                        out_strobe,
  output logic [fpdf_pkg::CHAR_W-1:0] out_text_char,
  output logic                        out_is_last
);

  localparam int N_DIV = fpdf_pkg::NUM_FRAC;

  logic                 stall;
  logic                 adv;
  logic                 accept;
  logic                 in_range;

  // input register stage
  logic                 v0_r;
  fpdf_pkg::fpdf_work_t w0_r;
  fpdf_pkg::fpdf_work_t w0_nxt;

  // divide chain taps
  logic                 dv   [N_DIV+1];
  fpdf_pkg::fpdf_work_t dw   [N_DIV+1];

  assign adv      = !stall;
  assign busy     = stall;
  assign accept   = start && !busy;
  assign in_range = (in_time_value < fpdf_pkg::VALUE_LIMIT);

  always_comb begin
    w0_nxt.rem    = in_time_value[fpdf_pkg::REM_W-1:0];
    w0_nxt.digits = '0;
  end

  // out-of-range values never get a valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (adv) begin
      v0_r <= accept && in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      w0_r <= w0_nxt;
    end
  end

  assign dv[0] = v0_r;
  assign dw[0] = w0_r;

  // one decimal digit per stage, low digit first
  for (genvar g = 0; g < N_DIV; g++) begin : g_div
    fpdf_div10_stage u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (adv),
      .in_valid  (dv[g]),
      .in_work   (dw[g]),
      .out_valid (dv[g+1]),
      .out_work  (dw[g+1])
    );
  end

  // after the last stage the remainder is the leading digit
  fpdf_serializer u_ser (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (dv[N_DIV]),
    .in_work       (dw[N_DIV]),
    .stall         (stall),
    .out_strobe    (out_strobe),
    .out_text_char (out_text_char),
    .out_is_last   (out_is_last)
  );

endmodule

// ===== sim/fixed_point_decimal_formatter_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_decimal_formatter_tb
// self-checking bench for the D.DDDD time formatter
// ----------------------------------------------------------------------------
// a directed table of values runs first: zero, the top of the range, digit
// boundaries and values at and past the limit. Random values follow in three
// sender idle phases. Every accepted in-range value is turned into its
// expected character beats, by a local formatter or from the text typed in
// the table; each output beat is matched against the oldest one in order.
// ----------------------------------------------------------------------------
module fixed_point_decimal_formatter_tb;

  localparam int unsigned TIME_LIMIT = 100000;
  localparam logic [7:0]  CHAR_ZERO  = 8'h30;
  localparam logic [7:0]  CHAR_DOT   = 8'h2E;
  localparam int          TEXT_LEN   = 6;
  localparam int          NUM_RANDOM = 67;   // per idle phase
  localparam int          DRAIN_CYCLES = 20;

  typedef enum logic [1:0] {
    ROW_PREDICT,   // expectation from the local formatter
    ROW_TEXT,      // expectation typed into the table
    ROW_DROP       // out of range, no beats
  } row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [31:0] value;
    logic [47:0] text;
  } directed_row_t;

  typedef struct {
    logic [fpdf_pkg::CHAR_W-1:0] text_char;
    logic                        is_last;
  } char_beat_t;

  logic                          clk;
  logic                          rst_n = 1'b0;
  logic                          start = 1'b0;
  logic                          busy;
  logic [fpdf_pkg::IN_W-1:0]     in_time_value = '0;
  logic                          out_strobe;
  logic [fpdf_pkg::CHAR_W-1:0]   out_text_char;
  logic                          out_is_last;

  char_beat_t          expected_chars[$];
  int                  fail_count = 0;
  int                  sender_idle_pct = 0;

  localparam int NUM_DIRECTED = 23;
  directed_row_t directed_rows [NUM_DIRECTED] = '{
    '{ROW_TEXT,    32'd0,          "0.0000"},
    '{ROW_TEXT,    32'd99999,      "9.9999"},
    '{ROW_TEXT,    32'd1,          "0.0001"},
    '{ROW_TEXT,    32'd10000,      "1.0000"},
    '{ROW_DROP,    32'd100000,     48'h0},
    '{ROW_DROP,    32'hFFFF_FFFF,  48'h0},
    '{ROW_DROP,    32'd100001,     48'h0},
    '{ROW_DROP,    32'h8000_0000,  48'h0},
    '{ROW_PREDICT, 32'd9,          48'h0},
    '{ROW_PREDICT, 32'd10,         48'h0},
    '{ROW_PREDICT, 32'd99,         48'h0},
    '{ROW_PREDICT, 32'd100,        48'h0},
    '{ROW_PREDICT, 32'd999,        48'h0},
    '{ROW_PREDICT, 32'd1000,       48'h0},
    '{ROW_PREDICT, 32'd9999,       48'h0},
    '{ROW_PREDICT, 32'd12345,      48'h0},
    '{ROW_PREDICT, 32'd54321,      48'h0},
    '{ROW_PREDICT, 32'd65535,      48'h0},
    '{ROW_PREDICT, 32'd65536,      48'h0},
    '{ROW_PREDICT, 32'd90909,      48'h0},
    '{ROW_PREDICT, 32'd50505,      48'h0},
    '{ROW_DROP,    32'd131071,     48'h0},
    '{ROW_PREDICT, 32'd99998,      48'h0}
  };

  fixed_point_decimal_formatter i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_time_value (in_time_value),
    .out_strobe    (out_strobe),
    .out_text_char (out_text_char),
    .out_is_last   (out_is_last)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // split a value into its six characters, whole digit first
  function automatic void predict_time_text(input logic [31:0] value);
    logic [31:0]                 rest;
    logic [fpdf_pkg::CHAR_W-1:0] text [TEXT_LEN];
    char_beat_t                  beat;
    if (value >= TIME_LIMIT) begin
      return;
    end
    rest = value;
    for (int pos = TEXT_LEN - 1; pos >= 2; pos--) begin
      text[pos] = CHAR_ZERO + fpdf_pkg::CHAR_W'(rest % 10);
      rest = rest / 10;
    end
    text[1] = CHAR_DOT;
    text[0] = CHAR_ZERO + fpdf_pkg::CHAR_W'(rest % 10);
    for (int pos = 0; pos < TEXT_LEN; pos++) begin
      beat.text_char = text[pos];
      beat.is_last   = (pos == TEXT_LEN - 1);
      expected_chars.push_back(beat);
    end
  endfunction

  // returns at the edge where the value is taken
  task automatic send_value(input logic [31:0] value);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start         <= 1'b0;
      in_time_value <= $urandom();
      @(posedge clk);
    end
    start         <= 1'b1;
    in_time_value <= value;
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
  endtask

  initial begin : stimulus
    logic [31:0] value;
    char_beat_t  beat;
    int          mode;
    int          idle_by_phase [3];
    idle_by_phase = '{10, 56, 0};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    sender_idle_pct = idle_by_phase[0];
    foreach (directed_rows[r]) begin
      send_value(directed_rows[r].value);
      case (directed_rows[r].kind)
        ROW_TEXT: begin
          for (int k = 0; k < TEXT_LEN; k++) begin
            beat.text_char = directed_rows[r].text[47 - 8 * k -: 8];
            beat.is_last   = (k == TEXT_LEN - 1);
            expected_chars.push_back(beat);
          end
        end
        ROW_PREDICT: begin
          predict_time_text(directed_rows[r].value);
        end
        default: begin
          // out of range, nothing should come out
        end
      endcase
    end

    // mostly in-range values, some just past the limit and some full width
    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct = idle_by_phase[phase];
      for (int i = 0; i < NUM_RANDOM; i++) begin
        mode = $urandom_range(0, 9);
        if (mode == 0) begin
          value = $urandom();
        end else if (mode == 1) begin
          value = $urandom_range(TIME_LIMIT, 2 * TIME_LIMIT);
        end else if (mode == 2) begin
          value = $urandom_range(0, 9) * 11111;
        end else begin
          value = $urandom_range(0, TIME_LIMIT - 1);
        end
        send_value(value);
        predict_time_text(value);
      end
    end
    start <= 1'b0;

    while (expected_chars.size() != 0) begin
      @(posedge clk);
    end
    // catch stray beats after the last expected one
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("fixed_point_decimal_formatter regression: pass");
    end else begin
      $display("fixed_point_decimal_formatter regression: fail");
    end
    $finish;
  end

  // output beats are sampled at the edge that ends their cycle
  always @(posedge clk) begin
    char_beat_t want;
    if (rst_n && out_strobe) begin
      if (expected_chars.size() == 0) begin
        $error("unexpected beat: out_text_char %h out_is_last %b",
               out_text_char, out_is_last);
        fail_count++;
      end else begin
        want = expected_chars.pop_front();
        if (out_text_char !== want.text_char) begin
          $error("out_text_char: expected %h, got %h", want.text_char, out_text_char);
          fail_count++;
        end
        if (out_is_last !== want.is_last) begin
          $error("out_is_last: expected %b, got %b", want.is_last, out_is_last);
          fail_count++;
        end
      end
    end
  end

  initial begin : watchdog
    #1_000_000;
    $display("fixed_point_decimal_formatter regression: fail");
    $finish;
  end

endmodule
